### src/lbc_pkg.sv
// Shared types and constants of the block buffer cache tag engine.
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int BufCount = 32;
  localparam int SlotW = $clog2(BufCount);
  localparam int IdxW = $clog2(BufCount + 1);

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_RANGE   = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_DISK_BLOCKS = 1'd0,
    REG_NONE        = 1'd1
  } reg_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  count;
    logic [7:0]  dev;
    logic [15:0] blk;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    entry_t           wr_data;
  } store_req_t;

  typedef struct packed {
    logic [SlotW-1:0] rd_idx;
    logic             promote;
  } rank_req_t;

endpackage

### src/lbc_store.sv
// Slot store: tags, reference counts and valid marks, one read and one write port.
`timescale 1ns / 1ps

module lbc_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbc_pkg::store_req_t req_i,
  output lbc_pkg::entry_t     rd_data_o
);

  lbc_pkg::entry_t                mem [lbc_pkg::BufCount];
  logic [lbc_pkg::BufCount-1:0]   written_q;
  lbc_pkg::entry_t                rd_data_q;
  logic                           rd_written_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  // never-written slots read as the reset value
  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

### src/lbc_rank.sv
// Recency ranks of all slots; rank 0 is the most recently released slot.
`timescale 1ns / 1ps

module lbc_rank (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbc_pkg::rank_req_t          req_i,
  output logic [lbc_pkg::SlotW-1:0]   rank_o
);

  logic [lbc_pkg::SlotW-1:0] rank_q [lbc_pkg::BufCount];

  assign rank_o = rank_q[req_i.rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lbc_pkg::BufCount; i++) begin
        rank_q[i] <= lbc_pkg::SlotW'(lbc_pkg::BufCount - 1 - i);
      end
    end else if (req_i.promote) begin
      for (int i = 0; i < lbc_pkg::BufCount; i++) begin
        if (lbc_pkg::SlotW'(i) == req_i.rd_idx) begin
          rank_q[i] <= '0;
        end else if (rank_q[i] < rank_o) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

endmodule

### src/lbc_seq.sv
// Command sequencer: slot scan with a shared tag/rank compare, then update and report.
`timescale 1ns / 1ps

module lbc_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [7:0]                  device_id_i,
  input  logic [15:0]                 block_number_i,
  input  logic [4:0]                  slot_index_i,
  input  logic [15:0]                 disk_blocks_i,
  output lbc_pkg::store_req_t         store_req_o,
  input  lbc_pkg::entry_t             rd_data_i,
  output lbc_pkg::rank_req_t          rank_req_o,
  input  logic [lbc_pkg::SlotW-1:0]   rank_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [4:0]                  slot_o,
  output logic                        hit_o,
  output logic                        needs_fill_o,
  output logic [7:0]                  count_after_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GET_END,
    S_SLOT
  } state_e;

  localparam int SlotW = lbc_pkg::SlotW;
  localparam int IdxW = lbc_pkg::IdxW;

  state_e               state_q;
  lbc_pkg::cmd_e        cmd_q;
  logic [7:0]           dev_q;
  logic [15:0]          blk_q;
  logic [SlotW-1:0]     si_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic [SlotW-1:0]     chk_idx_q;
  logic                 found_q;
  logic [SlotW-1:0]     found_slot_q;
  logic [SlotW-1:0]     found_rank_q;
  logic [7:0]           found_cnt_q;
  logic                 found_valid_q;
  logic                 victim_q;
  logic [SlotW-1:0]     victim_slot_q;
  logic [SlotW-1:0]     victim_rank_q;
  logic                 done_q;
  lbc_pkg::status_e     status_q;
  logic [4:0]           slot_q;
  logic                 hit_q;
  logic                 fill_q;
  logic [7:0]           count_q;

  logic                 accept;
  lbc_pkg::cmd_e        cmd_in;
  logic                 blk_ok;
  logic                 si_ok;
  logic                 is_match;
  logic                 take_found;
  logic                 take_victim;
  logic                 slot_err;
  logic [7:0]           slot_cnt_new;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign cmd_in = lbc_pkg::cmd_e'(command_i);
  assign blk_ok = (block_number_i < disk_blocks_i);
  assign si_ok  = (int'(slot_index_i) < lbc_pkg::BufCount);

  // shared compare of the entry under scan
  assign is_match    = (rd_data_i.dev == dev_q) && (rd_data_i.blk == blk_q);
  assign take_found  = is_match && (!found_q || (rank_i < found_rank_q));
  assign take_victim = (rd_data_i.count == 8'd0) && (!victim_q || (rank_i > victim_rank_q));

  always_comb begin
    if (cmd_q == lbc_pkg::CMD_PIN) begin
      slot_err     = (rd_data_i.count == 8'hFF);
      slot_cnt_new = rd_data_i.count + 8'd1;
    end else begin
      slot_err     = (rd_data_i.count == 8'd0);
      slot_cnt_new = rd_data_i.count - 8'd1;
    end
  end

  always_comb begin
    store_req_o         = '0;
    rank_req_o.rd_idx   = (state_q == S_SLOT) ? si_q : chk_idx_q;
    rank_req_o.promote  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_in == lbc_pkg::CMD_GET && blk_ok) begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = '0;
        end else if (accept && cmd_in != lbc_pkg::CMD_GET && si_ok) begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = SlotW'(slot_index_i);
        end
      end
      S_SCAN: begin
        if (rd_idx_q < IdxW'(lbc_pkg::BufCount)) begin
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = rd_idx_q[SlotW-1:0];
        end
      end
      S_GET_END: begin
        if (found_q) begin
          if (found_cnt_q != 8'hFF) begin
            store_req_o.wr_en   = 1'b1;
            store_req_o.wr_addr = found_slot_q;
            store_req_o.wr_data = '{valid: 1'b1, count: found_cnt_q + 8'd1,
                                    dev: dev_q, blk: blk_q};
          end
        end else if (victim_q) begin
          store_req_o.wr_en   = 1'b1;
          store_req_o.wr_addr = victim_slot_q;
          store_req_o.wr_data = '{valid: 1'b1, count: 8'd1, dev: dev_q, blk: blk_q};
        end
      end
      S_SLOT: begin
        if (!slot_err) begin
          store_req_o.wr_en         = 1'b1;
          store_req_o.wr_addr       = si_q;
          store_req_o.wr_data       = rd_data_i;
          store_req_o.wr_data.count = slot_cnt_new;
          rank_req_o.promote = (cmd_q == lbc_pkg::CMD_RELEASE) && (slot_cnt_new == 8'd0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= lbc_pkg::CMD_GET;
      dev_q         <= '0;
      blk_q         <= '0;
      si_q          <= '0;
      rd_idx_q      <= '0;
      chk_idx_q     <= '0;
      found_q       <= 1'b0;
      found_slot_q  <= '0;
      found_rank_q  <= '0;
      found_cnt_q   <= '0;
      found_valid_q <= 1'b0;
      victim_q      <= 1'b0;
      victim_slot_q <= '0;
      victim_rank_q <= '0;
      done_q        <= 1'b0;
      status_q      <= lbc_pkg::ST_OK;
      slot_q        <= '0;
      hit_q         <= 1'b0;
      fill_q        <= 1'b0;
      count_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q     <= cmd_in;
            dev_q     <= device_id_i;
            blk_q     <= block_number_i;
            si_q      <= SlotW'(slot_index_i);
            found_q   <= 1'b0;
            victim_q  <= 1'b0;
            rd_idx_q  <= IdxW'(1);
            chk_idx_q <= '0;
            hit_q     <= 1'b0;
            fill_q    <= 1'b0;
            count_q   <= '0;
            if (cmd_in == lbc_pkg::CMD_GET) begin
              if (blk_ok) begin
                state_q <= S_SCAN;
              end else begin
                done_q   <= 1'b1;
                status_q <= lbc_pkg::ST_RANGE;
                slot_q   <= '0;
              end
            end else if (si_ok) begin
              state_q <= S_SLOT;
            end else begin
              done_q   <= 1'b1;
              status_q <= lbc_pkg::ST_OK;
              slot_q   <= slot_index_i;
            end
          end
        end
        S_SCAN: begin
          if (rd_idx_q < IdxW'(lbc_pkg::BufCount)) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (take_found) begin
            found_q       <= 1'b1;
            found_slot_q  <= chk_idx_q;
            found_rank_q  <= rank_i;
            found_cnt_q   <= rd_data_i.count;
            found_valid_q <= rd_data_i.valid;
          end
          if (take_victim) begin
            victim_q      <= 1'b1;
            victim_slot_q <= chk_idx_q;
            victim_rank_q <= rank_i;
          end
          chk_idx_q <= chk_idx_q + 1'b1;
          if (chk_idx_q == SlotW'(lbc_pkg::BufCount - 1)) begin
            state_q <= S_GET_END;
          end
        end
        S_GET_END: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
          if (found_q) begin
            slot_q <= 5'(found_slot_q);
            hit_q  <= 1'b1;
            if (found_cnt_q == 8'hFF) begin
              status_q <= lbc_pkg::ST_OVER;
              count_q  <= 8'hFF;
            end else begin
              status_q <= lbc_pkg::ST_OK;
              count_q  <= found_cnt_q + 8'd1;
              fill_q   <= !found_valid_q;
            end
          end else if (victim_q) begin
            status_q <= lbc_pkg::ST_OK;
            slot_q   <= 5'(victim_slot_q);
            count_q  <= 8'd1;
            fill_q   <= 1'b1;
          end else begin
            status_q <= lbc_pkg::ST_NO_FREE;
            slot_q   <= '0;
          end
        end
        S_SLOT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
          slot_q  <= 5'(si_q);
          if (slot_err) begin
            status_q <= (cmd_q == lbc_pkg::CMD_PIN) ? lbc_pkg::ST_OVER : lbc_pkg::ST_UNDER;
            count_q  <= rd_data_i.count;
          end else begin
            status_q <= lbc_pkg::ST_OK;
            count_q  <= slot_cnt_new;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign hit_o         = hit_q;
  assign needs_fill_o  = fill_q;
  assign count_after_o = count_q;

endmodule

### src/lru_block_buffer_cache.sv
// Top level of the block buffer cache tag and replacement engine.
// Usage:
//   A transaction is taken at a rising edge with start high and busy low; its
//   fields are command_i, device_id_i, block_number_i and slot_index_i.
//   Each transaction yields exactly one result on status_o, slot_o, hit_o,
//   needs_fill_o and count_after_o, valid for the single cycle done_o is high.
//   The receiver cannot stall; results must be taken when done_o is high.
// Command flow:
//   get in range: one store read per slot, 32 slots scanned by the single store
//     port and the shared tag/rank comparator, then the update and report step.
//   release, pin, unpin: one store read, one write-back.
//   get out of range, or slot beyond the buffer count: result with no store access.
//   busy drops in the cycle done_o rises, so the next transaction may start then.
// Configuration:
//   disk_blocks at byte address 0 over the APB port (write or read, no wait).
// Reset:
//   rst_ni low clears all slot tags, counts and valid marks at once and sets
//   the recency order to slot 0 least recent; disk_blocks returns to 2048.
`timescale 1ns / 1ps

module lru_block_buffer_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [7:0]  device_id_i,
  input  logic [15:0] block_number_i,
  input  logic [4:0]  slot_index_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_o,
  output logic        hit_o,
  output logic        needs_fill_o,
  output logic [7:0]  count_after_o
);

  logic [15:0]                disk_blocks_q;
  lbc_pkg::reg_e              reg_sel;
  lbc_pkg::store_req_t        store_req;
  lbc_pkg::entry_t            rd_data;
  lbc_pkg::rank_req_t         rank_req;
  logic [lbc_pkg::SlotW-1:0]  rank;

  assign reg_sel = lbc_pkg::reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      lbc_pkg::REG_DISK_BLOCKS: prdata = {16'd0, disk_blocks_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_blocks_q <= 16'd2048;
    end else if (psel && penable && pwrite && pready &&
                 reg_sel == lbc_pkg::REG_DISK_BLOCKS) begin
      disk_blocks_q <= pwdata[15:0];
    end
  end

  lbc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .device_id_i   (device_id_i),
    .block_number_i(block_number_i),
    .slot_index_i  (slot_index_i),
    .disk_blocks_i (disk_blocks_q),
    .store_req_o   (store_req),
    .rd_data_i     (rd_data),
    .rank_req_o    (rank_req),
    .rank_i        (rank),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .hit_o         (hit_o),
    .needs_fill_o  (needs_fill_o),
    .count_after_o (count_after_o)
  );

  lbc_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_data_o(rd_data)
  );

  lbc_rank u_rank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rank_req),
    .rank_o(rank)
  );

endmodule

### dv/lru_block_buffer_cache_test.sv
// Self-checking testbench for the block buffer cache tag and replacement engine.
`timescale 1ns / 1ps

module lru_block_buffer_cache_test;

  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    lbc_pkg::status_e status;
    logic [4:0]       slot;
    logic             hit;
    logic             fill;
    logic [7:0]       count;
  } cache_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        start, busy, done_o, hit_o, needs_fill_o;
  logic [1:0]  command_i;
  logic [7:0]  device_id_i, count_after_o;
  logic [15:0] block_number_i;
  logic [4:0]  slot_index_i, slot_o;
  logic [2:0]  status_o;

  // Shadow copy of the cache state
  logic [15:0] sh_disk_blocks;
  logic [7:0]  sh_dev   [lbc_pkg::BufCount];
  logic [15:0] sh_blk   [lbc_pkg::BufCount];
  logic [7:0]  sh_cnt   [lbc_pkg::BufCount];
  logic        sh_valid [lbc_pkg::BufCount];
  logic [4:0]  sh_rank  [lbc_pkg::BufCount];

  cache_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  lru_block_buffer_cache uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .command_i, .device_id_i, .block_number_i, .slot_index_i,
    .done_o, .status_o, .slot_o, .hit_o, .needs_fill_o, .count_after_o
  );

  always #10 clk_i = ~clk_i;

  function automatic void reset_shadow();
    sh_disk_blocks = 16'd2048;
    for (int i = 0; i < lbc_pkg::BufCount; i++) begin
      sh_dev[i] = '0;
      sh_blk[i] = '0;
      sh_cnt[i] = '0;
      sh_valid[i] = 1'b0;
      sh_rank[i] = 5'(lbc_pkg::BufCount - 1 - i);
    end
  endfunction

  function automatic void promote_slot(int s);
    logic [4:0] rk;
    rk = sh_rank[s];
    for (int i = 0; i < lbc_pkg::BufCount; i++)
      if (sh_rank[i] < rk) sh_rank[i]++;
    sh_rank[s] = '0;
  endfunction

  function automatic cache_result_t cache_lookup(lbc_pkg::cmd_e cmd, logic [7:0] dev,
                                                 logic [15:0] blk, logic [4:0] si);
    cache_result_t r;
    int found, victim, s;
    r = '0;
    r.status = lbc_pkg::ST_OK;
    if (cmd == lbc_pkg::CMD_GET) begin
      if (blk >= sh_disk_blocks) begin
        r.status = lbc_pkg::ST_RANGE;
      end else begin
        found = -1;
        victim = -1;
        for (int i = 0; i < lbc_pkg::BufCount; i++)
          if (sh_dev[i] == dev && sh_blk[i] == blk &&
              (found < 0 || sh_rank[i] < sh_rank[found])) found = i;
        if (found >= 0) begin
          r.slot = 5'(found);
          r.hit = 1'b1;
          if (sh_cnt[found] == 8'd255) begin
            r.status = lbc_pkg::ST_OVER;
            r.count = 8'd255;
          end else begin
            sh_cnt[found]++;
            r.count = sh_cnt[found];
            r.fill = !sh_valid[found];
            sh_valid[found] = 1'b1;
          end
        end else begin
          for (int i = 0; i < lbc_pkg::BufCount; i++)
            if (sh_cnt[i] == 0 && (victim < 0 || sh_rank[i] > sh_rank[victim]))
              victim = i;
          if (victim < 0) begin
            r.status = lbc_pkg::ST_NO_FREE;
          end else begin
            r.slot = 5'(victim);
            sh_dev[victim] = dev;
            sh_blk[victim] = blk;
            sh_cnt[victim] = 8'd1;
            sh_valid[victim] = 1'b1;
            r.count = 8'd1;
            r.fill = 1'b1;
          end
        end
      end
    end else begin
      r.slot = si;
      s = int'(si);
      if (s < lbc_pkg::BufCount) begin
        if (cmd == lbc_pkg::CMD_PIN) begin
          if (sh_cnt[s] == 8'd255) r.status = lbc_pkg::ST_OVER;
          else sh_cnt[s]++;
        end else begin
          if (sh_cnt[s] == 8'd0) begin
            r.status = lbc_pkg::ST_UNDER;
          end else begin
            sh_cnt[s]--;
            if (cmd == lbc_pkg::CMD_RELEASE && sh_cnt[s] == 8'd0) promote_slot(s);
          end
        end
        r.count = sh_cnt[s];
      end
    end
    return r;
  endfunction

  // One transaction; returns at the edge that accepts it with start still high
  task automatic send_cmd(input lbc_pkg::cmd_e cmd, input logic [7:0] dev,
                          input logic [15:0] blk, input logic [4:0] si,
                          output cache_result_t exp);
    if (!no_idle)
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    start <= 1'b1;
    command_i <= cmd;
    device_id_i <= dev;
    block_number_i <= blk;
    slot_index_i <= si;
    do @(posedge clk_i); while (busy);
    exp = cache_lookup(cmd, dev, blk, si);
    pending_results.push_back(exp);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_disk_blocks(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {lbc_pkg::REG_DISK_BLOCKS, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sh_disk_blocks = value;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cache_result_t exp;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d slot %0d", $time,
                 status_o, slot_o);
      end else begin
        exp = pending_results.pop_front();
        if (exp.status !== status_o || exp.slot !== slot_o || exp.hit !== hit_o ||
            exp.fill !== needs_fill_o || exp.count !== count_after_o) begin
          errors++;
          $display("%0t: expected status %0d slot %0d hit %0b fill %0b count %0d, %s",
                   $time, exp.status, exp.slot, exp.hit, exp.fill, exp.count,
                   $sformatf("got status %0d slot %0d hit %0b fill %0b count %0d",
                             status_o, slot_o, hit_o, needs_fill_o, count_after_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_untouched_slots();
    cache_result_t r;
    send_cmd(lbc_pkg::CMD_GET, 8'd0, 16'd0, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd0, 16'd0, 5'd0, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'd31, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'd31, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'd31, r);
    send_cmd(lbc_pkg::CMD_UNPIN, 8'd0, 16'd0, 5'd3, r);
    send_cmd(lbc_pkg::CMD_PIN, 8'd0, 16'd0, 5'd3, r);
    send_cmd(lbc_pkg::CMD_UNPIN, 8'd0, 16'd0, 5'd3, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd255, 16'd2047, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd1, 16'd2048, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd0, 16'd65535, 5'd0, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, r.slot, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'd0, r);
    drain();
  endtask

  task automatic test_no_free_buffer();
    cache_result_t r;
    logic [4:0] hot;
    for (int i = 0; i < lbc_pkg::BufCount; i++)
      send_cmd(lbc_pkg::CMD_GET, 8'h5a, 16'(100 + i), 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'h5a, 16'd999, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'h5a, 16'd100, 5'd0, r);
    hot = r.slot;
    for (int i = 0; i < lbc_pkg::BufCount; i++)
      send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'(i), r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, hot, r);
    drain();
  endtask

  task automatic test_count_overflow();
    cache_result_t r;
    logic [4:0] s;
    send_cmd(lbc_pkg::CMD_GET, 8'd7, 16'd9, 5'd0, r);
    s = r.slot;
    repeat (255 - int'(r.count)) send_cmd(lbc_pkg::CMD_PIN, 8'd0, 16'd0, s, r);
    send_cmd(lbc_pkg::CMD_PIN, 8'd0, 16'd0, s, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd7, 16'd9, 5'd0, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, s, r);
    drain();
  endtask

  task automatic test_disk_bounds();
    cache_result_t r;
    write_disk_blocks(16'd1);
    send_cmd(lbc_pkg::CMD_GET, 8'd3, 16'd0, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd3, 16'd1, 5'd0, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, r.slot, r);
    drain();
    write_disk_blocks(16'd65535);
    send_cmd(lbc_pkg::CMD_GET, 8'd4, 16'd65534, 5'd0, r);
    send_cmd(lbc_pkg::CMD_GET, 8'd4, 16'd65535, 5'd0, r);
    send_cmd(lbc_pkg::CMD_RELEASE, 8'd0, 16'd0, 5'd0, r);
    drain();
  endtask

  function automatic logic [4:0] pick_held_slot();
    int held[$];
    for (int i = 0; i < lbc_pkg::BufCount; i++)
      if (sh_cnt[i] != 0) held.push_back(i);
    if (held.size() == 0 || $urandom_range(3) == 0) return 5'($urandom);
    return 5'(held[$urandom_range(held.size() - 1)]);
  endfunction

  function automatic logic [15:0] pick_block();
    int lim, pick;
    lim = int'(sh_disk_blocks);
    pick = $urandom_range(99);
    if (pick < 75) return 16'($urandom_range(0, (lim - 1 < 23) ? lim - 1 : 23));
    if (pick < 85) return 16'(lim - $urandom_range(1, 0));
    return 16'($urandom);
  endfunction

  task automatic test_random_traffic(input int n, input logic [15:0] disk, input bit quiet);
    cache_result_t r;
    int pick;
    logic [7:0] dev;
    write_disk_blocks(disk);
    no_idle = quiet;
    repeat (n) begin
      pick = $urandom_range(99);
      dev = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      if (pick < 42)
        send_cmd(lbc_pkg::CMD_GET, dev, pick_block(), 5'($urandom), r);
      else if (pick < 75)
        send_cmd(lbc_pkg::CMD_RELEASE, dev, 16'($urandom), pick_held_slot(), r);
      else if (pick < 87)
        send_cmd(lbc_pkg::CMD_PIN, dev, 16'($urandom), pick_held_slot(), r);
      else
        send_cmd(lbc_pkg::CMD_UNPIN, dev, 16'($urandom), pick_held_slot(), r);
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    reset_shadow();
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    command_i <= lbc_pkg::CMD_GET;
    device_id_i <= '0;
    block_number_i <= '0;
    slot_index_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_untouched_slots();
    test_no_free_buffer();
    test_count_overflow();
    test_disk_bounds();
    test_random_traffic(150, 16'd2048, 1'b0);
    test_random_traffic(80, 16'd1, 1'b0);
    test_random_traffic(150, 16'd65535, 1'b1);
    test_random_traffic(150, 16'($urandom_range(1, 65535)), 1'b0);
    test_random_traffic(100, 16'($urandom_range(2, 40)), 1'b0);

    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
